// ===== hw/rtl/wrsp_pkg.sv =====
package wrsp_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PREAMBLE,
    PH_HDR,
    PH_FMT,
    PH_DATA,
    PH_SKIP
  } phase_t;

  // Event kinds on event_kind
  localparam logic [3:0] EV_SAMPLE      = 4'd0;
  localparam logic [3:0] EV_NOT_RIFF    = 4'd1;
  localparam logic [3:0] EV_NOT_WAVE    = 4'd2;
  localparam logic [3:0] EV_BAD_TAG     = 4'd3;
  localparam logic [3:0] EV_BAD_CHAN    = 4'd4;
  localparam logic [3:0] EV_BAD_WIDTH   = 4'd5;
  localparam logic [3:0] EV_NO_FMT      = 4'd6;
  localparam logic [3:0] EV_PLAY_START  = 4'd7;
  localparam logic [3:0] EV_END         = 4'd8;

  // Little-endian chunk tags
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [15:0] PCM_TAG  = 16'h0001;

  // Rate band thresholds
  localparam logic [31:0] RATE_LO  = 32'd12500;
  localparam logic [31:0] RATE_MID = 32'd25000;
  localparam logic [31:0] RATE_HI  = 32'd50000;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [15:0] value;
    logic               chan;
    logic [1:0]         band;
    logic               last;
  } evt_t;

endpackage

// ===== hw/rtl/wrsp_out_stage.sv =====
module wrsp_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic               has_evt,
  input  wrsp_pkg::evt_t     evt,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         event_kind,
  output logic signed [15:0] sample_value,
  output logic               sample_channel,
  output logic [1:0]         rate_band,
  output logic               chunk_last
);

  wrsp_pkg::evt_t evt_q;

  // free when empty or being drained this cycle
  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= has_evt;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_evt) begin
      evt_q <= evt;
    end
  end

  assign event_kind     = evt_q.kind;
  assign sample_value   = evt_q.value;
  assign sample_channel = evt_q.chan;
  assign rate_band      = evt_q.band;
  assign chunk_last     = evt_q.last;

endmodule

// ===== hw/rtl/wave_riff_stream_parser.sv =====
// Streaming RIFF/WAVE parser. One file byte is taken per request on the input
// channel; file_start marks byte 0 of a new file and restarts the parser. The
// preamble must read "RIFF", size, "WAVE"; chunk headers follow. The first 16
// body bytes of a "fmt " chunk are parsed. A "data" chunk plays only for PCM tag
// 1, two channels and block_align/2 == 2: it gives a play-start event with the
// rate band, then signed 16-bit samples, left first, with chunk_last on the
// last one. Any other chunk is skipped (no pad byte). Parsing stops at byte
// offset riff_size + 8, reported when the next chunk header would start.
// Rate: one byte per clock while out_ready holds. Each byte is parsed in the cycle it is
// accepted and its result, if any, sits in the output register the next
// cycle. The single output register sets the rate: in_ready is high whenever
// that register is empty or being taken in the same cycle, so in_ready
// follows out_ready combinationally.
module wave_riff_stream_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         file_byte,
  input  logic               file_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         event_kind,
  output logic signed [15:0] sample_value,
  output logic               sample_channel,
  output logic [1:0]         rate_band,
  output logic               chunk_last
);

  // Parser state
  wrsp_pkg::phase_t phase, phase_next;
  logic [31:0] file_offset, file_offset_next;
  logic [31:0] riff_length, riff_length_next;
  logic [32:0] riff_end;  // riff_length + 8, registered from riff_length
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic [2:0]  hdr_cnt, hdr_cnt_next;
  logic [15:0] format_tag, format_tag_next;
  logic [15:0] channel_count, channel_count_next;
  logic [31:0] sample_rate, sample_rate_next;
  logic [15:0] block_align, block_align_next;
  logic        format_seen, format_seen_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic [1:0]  byte_phase, byte_phase_next;
  logic [4:0]  fmt_index, fmt_index_next;

  logic [31:0]    off;
  logic [31:0]    rem_dec;
  logic           emit;
  wrsp_pkg::evt_t evt;
  logic           take;
  logic           room;

  assign in_ready = room;
  assign take     = in_valid && room;

  // ---------------------------------------------------------------------
  // Per-byte parse step
  // ---------------------------------------------------------------------
  always_comb begin
    // file_start wipes the state, then the byte is parsed as byte 0
    if (file_start) begin
      phase_next           = wrsp_pkg::PH_PREAMBLE;
      file_offset_next     = '0;
      riff_length_next     = '0;
      chunk_tag_next       = '0;
      chunk_remaining_next = '0;
      hdr_cnt_next         = '0;
      format_tag_next      = '0;
      channel_count_next   = '0;
      sample_rate_next     = '0;
      block_align_next     = '0;
      format_seen_next     = 1'b0;
      low_byte_hold_next   = '0;
      byte_phase_next      = '0;
      fmt_index_next       = '0;
    end else begin
      phase_next           = phase;
      file_offset_next     = file_offset;
      riff_length_next     = riff_length;
      chunk_tag_next       = chunk_tag;
      chunk_remaining_next = chunk_remaining;
      hdr_cnt_next         = hdr_cnt;
      format_tag_next      = format_tag;
      channel_count_next   = channel_count;
      sample_rate_next     = sample_rate;
      block_align_next     = block_align;
      format_seen_next     = format_seen;
      low_byte_hold_next   = low_byte_hold;
      byte_phase_next      = byte_phase;
      fmt_index_next       = fmt_index;
    end

    off     = file_offset_next;
    rem_dec = chunk_remaining_next - 32'd1;
    emit    = 1'b0;
    evt     = '0;

    // saturating byte offset
    if (phase_next != wrsp_pkg::PH_IDLE && off != 32'hFFFF_FFFF) begin
      file_offset_next = off + 32'd1;
    end

    unique case (phase_next)
      wrsp_pkg::PH_IDLE: begin
      end

      wrsp_pkg::PH_PREAMBLE: begin
        if (off < 32'd4 || off >= 32'd8) begin
          if (off[1:0] == 2'd0) begin
            chunk_tag_next = '0;
          end
          chunk_tag_next[{off[1:0], 3'b000} +: 8] = file_byte;
          if (off == 32'd3 && chunk_tag_next != wrsp_pkg::TAG_RIFF) begin
            phase_next = wrsp_pkg::PH_IDLE;
            emit       = 1'b1;
            evt.kind   = wrsp_pkg::EV_NOT_RIFF;
          end
          if (off == 32'd11) begin
            if (chunk_tag_next != wrsp_pkg::TAG_WAVE) begin
              phase_next = wrsp_pkg::PH_IDLE;
              emit       = 1'b1;
              evt.kind   = wrsp_pkg::EV_NOT_WAVE;
            end else begin
              phase_next   = wrsp_pkg::PH_HDR;
              hdr_cnt_next = '0;
            end
          end
        end else begin
          riff_length_next[{off[1:0], 3'b000} +: 8] = file_byte;
        end
      end

      wrsp_pkg::PH_HDR: begin
        if (hdr_cnt_next == 3'd0 && {1'b0, off} >= riff_end) begin
          phase_next = wrsp_pkg::PH_IDLE;
          emit       = 1'b1;
          evt.kind   = wrsp_pkg::EV_END;
        end else begin
          if (hdr_cnt_next == 3'd0) begin
            chunk_tag_next       = '0;
            chunk_remaining_next = '0;
          end
          if (!hdr_cnt_next[2]) begin
            chunk_tag_next[{hdr_cnt_next[1:0], 3'b000} +: 8] = file_byte;
          end else begin
            chunk_remaining_next[{hdr_cnt_next[1:0], 3'b000} +: 8] = file_byte;
          end
          if (hdr_cnt_next != 3'd7) begin
            hdr_cnt_next = hdr_cnt_next + 3'd1;
          end else begin
            hdr_cnt_next = '0;
            if (chunk_tag_next == wrsp_pkg::TAG_FMT) begin
              format_tag_next    = '0;
              channel_count_next = '0;
              sample_rate_next   = '0;
              block_align_next   = '0;
              format_seen_next   = 1'b1;
              fmt_index_next     = '0;
              phase_next = (chunk_remaining_next != '0) ? wrsp_pkg::PH_FMT
                                                        : wrsp_pkg::PH_HDR;
            end else if (chunk_tag_next == wrsp_pkg::TAG_DATA) begin
              emit = 1'b1;
              if (!format_seen_next) begin
                evt.kind = wrsp_pkg::EV_NO_FMT;
              end else if (format_tag_next != wrsp_pkg::PCM_TAG) begin
                evt.kind = wrsp_pkg::EV_BAD_TAG;
              end else if (channel_count_next != 16'd2) begin
                evt.kind = wrsp_pkg::EV_BAD_CHAN;
              end else if (block_align_next[15:1] != 15'd2) begin
                evt.kind = wrsp_pkg::EV_BAD_WIDTH;
              end else begin
                evt.kind = wrsp_pkg::EV_PLAY_START;
              end
              if (evt.kind == wrsp_pkg::EV_PLAY_START) begin
                if (sample_rate_next < wrsp_pkg::RATE_LO) begin
                  evt.band = 2'd0;
                end else if (sample_rate_next < wrsp_pkg::RATE_MID) begin
                  evt.band = 2'd1;
                end else if (sample_rate_next < wrsp_pkg::RATE_HI) begin
                  evt.band = 2'd2;
                end else begin
                  evt.band = 2'd3;
                end
                byte_phase_next    = '0;
                low_byte_hold_next = '0;
                phase_next = (chunk_remaining_next != '0) ? wrsp_pkg::PH_DATA
                                                          : wrsp_pkg::PH_HDR;
              end else begin
                phase_next = (chunk_remaining_next != '0) ? wrsp_pkg::PH_SKIP
                                                          : wrsp_pkg::PH_HDR;
              end
            end else begin
              phase_next = (chunk_remaining_next != '0) ? wrsp_pkg::PH_SKIP
                                                        : wrsp_pkg::PH_HDR;
            end
          end
        end
      end

      wrsp_pkg::PH_FMT: begin
        if (!fmt_index_next[4]) begin
          case (fmt_index_next[3:0])
            4'd0:  format_tag_next[7:0]     = file_byte;
            4'd1:  format_tag_next[15:8]    = file_byte;
            4'd2:  channel_count_next[7:0]  = file_byte;
            4'd3:  channel_count_next[15:8] = file_byte;
            4'd4:  sample_rate_next         = {24'd0, file_byte};
            4'd5:  sample_rate_next[15:8]   = file_byte;
            4'd6:  sample_rate_next[23:16]  = file_byte;
            4'd7:  sample_rate_next[31:24]  = file_byte;
            4'd12: block_align_next[7:0]    = file_byte;
            4'd13: block_align_next[15:8]   = file_byte;
            default: begin
            end
          endcase
          fmt_index_next = fmt_index_next + 5'd1;
        end
        chunk_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = wrsp_pkg::PH_HDR;
        end
      end

      wrsp_pkg::PH_DATA: begin
        chunk_remaining_next = rem_dec;
        if (!byte_phase_next[0]) begin
          low_byte_hold_next = file_byte;
        end else begin
          emit      = 1'b1;
          evt.kind  = wrsp_pkg::EV_SAMPLE;
          evt.value = {file_byte, low_byte_hold_next};
          evt.chan  = byte_phase_next[1];
          evt.last  = (rem_dec == '0);
        end
        byte_phase_next = byte_phase_next + 2'd1;
        if (rem_dec == '0) begin
          phase_next = wrsp_pkg::PH_HDR;
        end
      end

      wrsp_pkg::PH_SKIP: begin
        chunk_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = wrsp_pkg::PH_HDR;
        end
      end

      default: begin
        phase_next = wrsp_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= wrsp_pkg::PH_IDLE;
      file_offset     <= '0;
      riff_length     <= '0;
      chunk_tag       <= '0;
      chunk_remaining <= '0;
      hdr_cnt         <= '0;
      format_tag      <= '0;
      channel_count   <= '0;
      sample_rate     <= '0;
      block_align     <= '0;
      format_seen     <= 1'b0;
      low_byte_hold   <= '0;
      byte_phase      <= '0;
      fmt_index       <= '0;
    end else if (take) begin
      phase           <= phase_next;
      file_offset     <= file_offset_next;
      riff_length     <= riff_length_next;
      chunk_tag       <= chunk_tag_next;
      chunk_remaining <= chunk_remaining_next;
      hdr_cnt         <= hdr_cnt_next;
      format_tag      <= format_tag_next;
      channel_count   <= channel_count_next;
      sample_rate     <= sample_rate_next;
      block_align     <= block_align_next;
      format_seen     <= format_seen_next;
      low_byte_hold   <= low_byte_hold_next;
      byte_phase      <= byte_phase_next;
      fmt_index       <= fmt_index_next;
    end
  end

  // End offset; riff_length settles at byte 7, first used at byte 12 or later
  always_ff @(posedge clk) begin
    riff_end <= {1'b0, riff_length} + 33'd8;
  end

  wrsp_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .has_evt        (emit),
    .evt            (evt),
    .room           (room),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .sample_value   (sample_value),
    .sample_channel (sample_channel),
    .rate_band      (rate_band),
    .chunk_last     (chunk_last)
  );

endmodule

// ===== hw/rtl/wrsp_checker.sv =====
module wrsp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         file_byte,
  input logic               file_start,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         event_kind,
  input logic signed [15:0] sample_value,
  input logic               sample_channel,
  input logic [1:0]         rate_band,
  input logic               chunk_last
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind))
    else $error("result dropped while stalled");

  // empty output register must never block input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // sample fields only on samples, band only on play start
  a_field_use: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != wrsp_pkg::EV_SAMPLE |->
      sample_value == 16'sd0 && !sample_channel && !chunk_last)
    else $error("sample fields set on non-sample event");

  a_band_use: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != wrsp_pkg::EV_PLAY_START |-> rate_band == 2'd0)
    else $error("rate band set outside play start");

endmodule

bind wave_riff_stream_parser wrsp_checker u_chk (.*);
